### design/tclc_pkg.sv
package tclc_pkg;

    // Field widths
    localparam int NOW_W    = 32;
    localparam int LEVEL_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int DUR_W    = 15;

    // Time width range and default
    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_MAX_W    = 64;

    // Blend datapath: every lane works on level-wide values
    localparam int VAL_W     = LEVEL_W;
    localparam int PROD_W    = VAL_W + DUR_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int DIGIT_W   = 2;
    localparam int MUL_STEPS = (DUR_W + DIGIT_W - 1) / DIGIT_W;
    localparam int REM_SH_W  = MUL_STEPS * DIGIT_W;
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Lanes: level, red, green, blue
    localparam int NUM_LANES = 4;
    localparam int NUM_COLORS = 3;
    localparam int LANE_LEVEL = 0;

    // Reset gray for each color channel
    localparam logic [COLOR_W-1:0] GRAY_INIT = COLOR_W'(77);

    // Operation codes carried in tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Beat widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 40;

    // Per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic               load;
        logic               mul;
        logic               div_load;
        logic               div;
        logic [DIGIT_W-1:0] digit;
    } lane_ctrl_t;

endpackage

### design/tclc_lane.sv
module tclc_lane
    import tclc_pkg::*;
(
    input  logic               aclk,
    input  lane_ctrl_t         ctrl,
    input  logic [VAL_W-1:0]   from_val,
    input  logic [VAL_W-1:0]   tgt_val,
    input  logic [DUR_W-1:0]   fade_len,
    output logic [VAL_W-1:0]   result
);

    logic               up_reg;
    logic [VAL_W-1:0]   tgt_reg;
    logic [VAL_W-1:0]   mag_reg;
    logic [VAL_W+1:0]   mag3_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [VAL_W-1:0]   part_reg;
    logic [VAL_W-1:0]   quo_reg;

    logic               up_next;
    logic [VAL_W-1:0]   mag_next;
    logic [VAL_W+1:0]   mag3_next;
    logic [VAL_W+1:0]   pp;
    logic [PROD_W-1:0]  acc_next;
    logic [NUM_W-1:0]   num;
    logic [VAL_W:0]     trial;
    logic [VAL_W:0]     dvs;
    logic [VAL_W:0]     diff;
    logic               take;

    // Magnitude of the swing and its triple for radix-4 digits
    assign up_next   = (from_val >= tgt_val);
    assign mag_next  = up_next ? (from_val - tgt_val) : (tgt_val - from_val);
    assign mag3_next = {2'b00, mag_next} + {1'b0, mag_next, 1'b0};

    // Partial product for the current digit of the remaining time
    always_comb begin
        case (ctrl.digit)
            2'd0:    pp = '0;
            2'd1:    pp = {2'b00, mag_reg};
            2'd2:    pp = {1'b0, mag_reg, 1'b0};
            2'd3:    pp = mag3_reg;
            default: pp = '0;
        endcase
    end

    assign acc_next = {acc_reg[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(pp);

    // Dividend 2*mag*rem + len, divisor 2*len
    assign num   = {1'b0, acc_reg, 1'b0} + NUM_W'(fade_len);
    assign dvs   = {1'b0, fade_len, 1'b0};
    assign trial = {part_reg, quo_reg[VAL_W-1]};
    assign diff  = trial - dvs;
    assign take  = (trial >= dvs);

    // Multiply then restoring divide, one digit per cycle
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            up_reg   <= up_next;
            tgt_reg  <= tgt_val;
            mag_reg  <= mag_next;
            mag3_reg <= mag3_next;
            acc_reg  <= '0;
        end else if (ctrl.mul) begin
            acc_reg <= acc_next;
        end else if (ctrl.div_load) begin
            part_reg <= num[VAL_W +: VAL_W];
            quo_reg  <= num[VAL_W-1:0];
        end else if (ctrl.div) begin
            part_reg <= take ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            quo_reg  <= {quo_reg[VAL_W-2:0], take};
        end
    end

    // Apply the rounded offset toward the start value
    assign result = up_reg ? (tgt_reg + quo_reg) : (tgt_reg - quo_reg);

endmodule

### design/timed_color_level_crossfade_top.sv
// Timed crossfade of an RGB color plus a level.
// Input stream (s_axis_*): one beat per item. tuser[0] picks the operation:
// update (0) loads new targets and a fade duration, query (1) asks for the
// blended values at time now. Updates give no result beat; each query gives
// exactly one result beat on m_axis_*, with effect_on in tuser[0].
// Each item runs through a sequencer: a step to compare the fade end with
// now, another to saturate the remaining time and load the four lanes (level,
// red, green, blue), a radix-4 multiply of the swing by the remaining time,
// another step to form the dividend, a one-bit restoring divide by twice the
// fade length and a last step that retires the item. The lanes run side by
// side. A new beat is accepted only once the last item has retired; a query
// result is loaded into the output register in its last step.
// s_axis_tready is high only while the sequencer is idle.
// A result waits in the output register while the receiver stalls; the next
// item is accepted and computed meanwhile. A query then holds in its last step
// until the output register is free; an update retires without waiting.
// Reset (aresetn low, synchronous) drops any pending result, sets the targets
// and start values to gray 77 with level 0, and clears the fade and enable.
module timed_color_level_crossfade_top
    import tclc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // now[31:0], new_level[47:32], new_red[55:48], new_green[63:56],
    // new_blue[71:64], fade_duration[86:72], zero pad[87]
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic [0:0]             s_axis_tuser,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_level[39:24]
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // effect_on[0]
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_LOAD,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [STEP_W-1:0]    step_reg;

    // Captured item
    logic                 op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [LEVEL_W-1:0]   new_level_reg;
    logic [COLOR_W-1:0]   new_rgb_reg [NUM_COLORS];
    logic [DUR_W-1:0]     dur_reg;

    // Fade state
    logic [LEVEL_W-1:0]   target_level_reg;
    logic [COLOR_W-1:0]   target_rgb_reg [NUM_COLORS];
    logic [LEVEL_W-1:0]   start_level_reg;
    logic [COLOR_W-1:0]   start_rgb_reg [NUM_COLORS];
    logic [DUR_W-1:0]     fade_length_reg;
    logic [TIME_BITS-1:0] fade_end_reg;
    logic                 enabled_reg;

    // Remaining-time path
    logic                 idle_fade_reg;
    logic                 far_reg;
    logic [DUR_W-1:0]     near_reg;
    logic [REM_SH_W-1:0]  rem_sh_reg;
    logic                 rem_zero_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    logic [TIME_MAX_W-1:0] now_wide;
    logic [TIME_BITS:0]    time_diff;
    logic [DUR_W-1:0]      rem_val;
    logic                  s_accept;
    logic                  out_free;
    logic                  out_load;
    lane_ctrl_t            lane_ctrl;
    logic [VAL_W-1:0]      lane_from [NUM_LANES];
    logic [VAL_W-1:0]      lane_tgt  [NUM_LANES];
    logic [VAL_W-1:0]      lane_res  [NUM_LANES];
    logic [VAL_W-1:0]      blended   [NUM_LANES];
    logic [LEVEL_W-1:0]    q_level;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (op_reg == OP_QUERY) && out_free;

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

    // Time taken modulo 2^TIME_BITS
    assign now_wide = {{(TIME_MAX_W-NOW_W){1'b0}}, s_axis_tdata[NOW_W-1:0]};

    // Fade end minus now, with borrow on top
    assign time_diff = {1'b0, fade_end_reg} - {1'b0, now_reg};

    // Remaining ticks saturated at the fade length, zero when no fade is running
    assign rem_val = idle_fade_reg ? '0
                   : ((far_reg || (near_reg > fade_length_reg)) ? fade_length_reg : near_reg);

    // Lane commands
    always_comb begin
        lane_ctrl.load     = (state_reg == ST_LOAD);
        lane_ctrl.mul      = (state_reg == ST_MUL);
        lane_ctrl.div_load = (state_reg == ST_DLOAD);
        lane_ctrl.div      = (state_reg == ST_DIV);
        lane_ctrl.digit    = rem_sh_reg[REM_SH_W-1 -: DIGIT_W];
    end

    // Lane operands: level first, then red, green, blue
    always_comb begin
        lane_from[LANE_LEVEL] = start_level_reg;
        lane_tgt[LANE_LEVEL]  = target_level_reg;
        for (int k = 0; k < NUM_COLORS; k++) begin
            lane_from[k+1] = VAL_W'(start_rgb_reg[k]);
            lane_tgt[k+1]  = VAL_W'(target_rgb_reg[k]);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tclc_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .from_val (lane_from[g]),
            .tgt_val  (lane_tgt[g]),
            .fade_len (fade_length_reg),
            .result   (lane_res[g])
        );
    end

    // No fade running: the targets stand
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            blended[k] = rem_zero_reg ? lane_tgt[k] : lane_res[k];
        end
    end

    assign q_level = enabled_reg ? blended[LANE_LEVEL] : '0;

    // Capture the item on accept
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg        <= s_axis_tuser[0];
            now_reg       <= now_wide[TIME_BITS-1:0];
            new_level_reg <= s_axis_tdata[47:32];
            new_rgb_reg[0] <= s_axis_tdata[55:48];
            new_rgb_reg[1] <= s_axis_tdata[63:56];
            new_rgb_reg[2] <= s_axis_tdata[71:64];
            dur_reg       <= s_axis_tdata[86:72];
        end
    end

    // Remaining-time stages
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIFF) begin
            idle_fade_reg <= time_diff[TIME_BITS] || (time_diff[TIME_BITS-1:0] == '0)
                             || (fade_length_reg == '0);
            far_reg       <= |time_diff[TIME_BITS-1:DUR_W];
            near_reg      <= time_diff[DUR_W-1:0];
        end
        if (state_reg == ST_LOAD) begin
            rem_sh_reg   <= REM_SH_W'(rem_val);
            rem_zero_reg <= (rem_val == '0);
        end else if (state_reg == ST_MUL) begin
            rem_sh_reg <= {rem_sh_reg[REM_SH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    // Sequencer, fade state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
            target_level_reg <= '0;
            start_level_reg  <= '0;
            for (int k = 0; k < NUM_COLORS; k++) begin
                target_rgb_reg[k] <= GRAY_INIT;
                start_rgb_reg[k]  <= GRAY_INIT;
            end
            fade_length_reg  <= '0;
            fade_end_reg     <= '0;
            enabled_reg      <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the receiver takes it
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                        state_reg <= ST_DLOAD;
                    end
                end
                ST_DLOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (op_reg == OP_UPDATE) begin
                        // Snapshot the blend as the new start when a fade begins
                        if (dur_reg != '0) begin
                            start_level_reg <= blended[LANE_LEVEL];
                            for (int k = 0; k < NUM_COLORS; k++) begin
                                start_rgb_reg[k] <= blended[k+1][COLOR_W-1:0];
                            end
                        end
                        target_level_reg <= new_level_reg;
                        for (int k = 0; k < NUM_COLORS; k++) begin
                            target_rgb_reg[k] <= new_rgb_reg[k];
                        end
                        enabled_reg     <= (dur_reg != '0) || (new_level_reg != '0);
                        fade_length_reg <= dur_reg;
                        fade_end_reg    <= now_reg + TIME_BITS'(dur_reg);
                        state_reg       <= ST_IDLE;
                    end else if (out_free) begin
                        m_data_reg  <= {q_level,
                                        blended[3][COLOR_W-1:0],
                                        blended[2][COLOR_W-1:0],
                                        blended[1][COLOR_W-1:0]};
                        m_user_reg  <= enabled_reg && (q_level != '0);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Remaining time never exceeds the fade length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |=> (rem_sh_reg <= REM_SH_W'(fade_length_reg)))
        else $error("remaining time above fade length");

    // A rounded color blend stays within one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && !rem_zero_reg) |->
            ((lane_res[1][VAL_W-1:COLOR_W] == '0) && (lane_res[2][VAL_W-1:COLOR_W] == '0)
             && (lane_res[3][VAL_W-1:COLOR_W] == '0)))
        else $error("color blend out of range");

    // effect_on only with a nonzero level
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg) |-> (m_data_reg[M_TDATA_W-1 -: LEVEL_W] != '0))
        else $error("effect on with zero level");

    // An update retires in its last step without a result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && (op_reg == OP_UPDATE) && !m_valid_reg) |=>
            ((state_reg == ST_IDLE) && !m_valid_reg))
        else $error("update produced a result or stalled");

endmodule
